### rtl/lru_kv_pkg.sv
`default_nettype none

package lru_kv_pkg;

    // built store size, default for the top level parameter
    localparam int ENTRIES_DEF = 16;

    // payload field widths
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 16;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CAP_W      = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // register word index (paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    // operation codes
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [KEY_BITS-1:0]   lookup_key;
        logic [VALUE_BITS-1:0] write_value;
    } req_item_t;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
    } rsp_item_t;

endpackage

`default_nettype wire

### rtl/lru_key_value_cache.sv
`default_nettype none

// Fully associative LRU key/value cache with ENTRIES slots. Each request
// transaction is a get or a put and yields exactly one response
// transaction. Keys and values share one synchronous single-read memory and
// recency ranks live in a second one. Only the per-slot valid bits are
// flip-flops, and reset clears them at once, so no clearing pass is needed.
// A request runs two sweeps over the rank memory, one entry per cycle: a
// search sweep (key compare, LRU pick, first free slot) and an update sweep
// (read-modify-write of every rank). During the update sweep the key/value
// memory is parked on the hit slot so the hit value is ready at the end.
// The sweeps are paced by the one-entry-per-cycle read port of the rank
// memory. The request side stalls while a transaction is in flight. A
// finished response waits in an output register, so a new request is
// taken while that response is held; the next transaction waits in its
// finish step for as long as the held response is stalled.
// The capacity register (byte address 0) bounds occupancy growth to
// 1..ENTRIES: a put miss at or above it evicts the LRU entry first.
// Zero acts as 1 and anything above ENTRIES as ENTRIES.
module lru_key_value_cache #(
    parameter int ENTRIES = lru_kv_pkg::ENTRIES_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // request channel
    input  wire                                   req_valid,
    output logic                                  req_stall,
    input  wire  lru_kv_pkg::req_item_t           req_item,
    // response channel
    output logic                                  rsp_valid,
    input  wire                                   rsp_stall,
    output lru_kv_pkg::rsp_item_t                 rsp_item,
    // configuration port
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [lru_kv_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [lru_kv_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lru_kv_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                  pready
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int RANK_W = IDX_W;
    localparam int CMP_W  = (CNT_W > lru_kv_pkg::CAP_W) ? CNT_W : lru_kv_pkg::CAP_W;
    localparam int KB     = lru_kv_pkg::KEY_BITS;
    localparam int VB     = lru_kv_pkg::VALUE_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    logic [KB+VB-1:0]  kv_mem   [ENTRIES];
    logic [RANK_W-1:0] rank_mem [ENTRIES];

    logic [KB-1:0]     key_rd_reg;
    logic [VB-1:0]     val_rd_reg;
    logic [RANK_W-1:0] rank_rd_reg;

    // ------------------------------------------------------------------
    // Control registers (reset)
    // ------------------------------------------------------------------
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;        // sweep issue counter
    logic                     p_vld_reg, p_vld_next;    // read data is valid
    logic [IDX_W-1:0]         p_idx_reg, p_idx_next;    // slot of read data
    logic                     found_vld_reg, found_vld_next;
    logic                     lru_vld_reg, lru_vld_next;
    logic                     free_vld_reg, free_vld_next;
    logic [ENTRIES-1:0]       valid_reg, valid_next;
    logic [CNT_W-1:0]         occ_reg, occ_next;
    logic [lru_kv_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic                     out_vld_reg, out_vld_next;

    // ------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------
    lru_kv_pkg::req_item_t    item_reg, item_next;
    logic [IDX_W-1:0]         found_idx_reg, found_idx_next;
    logic [RANK_W-1:0]        found_rank_reg, found_rank_next;
    logic [IDX_W-1:0]         lru_idx_reg, lru_idx_next;
    logic [RANK_W-1:0]        lru_rank_reg, lru_rank_next;
    logic [KB-1:0]            lru_key_reg, lru_key_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    lru_kv_pkg::rsp_item_t    res_reg, res_next;
    lru_kv_pkg::rsp_item_t    out_reg, out_next;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic              issue;       // a sweep read goes out this cycle
    logic [IDX_W-1:0]  rd_idx;
    logic              last;        // processing the last slot of a sweep
    logic              v_cur;
    logic              cfg_wr;
    logic              is_put, hit, insert, evict, occ_ge_cap;
    logic [IDX_W-1:0]  slot_idx;
    logic [CMP_W-1:0]  cap_ext, occ_ext, eff_cap;
    logic              out_free;

    logic              kv_we, rank_we;
    logic [IDX_W-1:0]  kv_wr_idx;
    logic [IDX_W-1:0]  kv_rd_idx;
    logic [RANK_W-1:0] rank_wdata;

    assign issue  = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE))
                    && (cnt_reg < CNT_W'(ENTRIES));
    assign rd_idx = issue ? cnt_reg[IDX_W-1:0] : '0;
    assign last   = p_vld_reg && (p_idx_reg == IDX_W'(ENTRIES - 1));
    assign v_cur  = valid_reg[p_idx_reg];

    // effective capacity: zero acts as one, clipped to the store size
    assign cap_ext = CMP_W'(cap_reg);
    assign occ_ext = CMP_W'(occ_reg);
    always_comb
    begin
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end
    assign occ_ge_cap = (occ_ext >= eff_cap);

    // decision, stable from the end of the search sweep on
    assign is_put = (item_reg.kind == lru_kv_pkg::KIND_PUT);
    assign hit    = found_vld_reg;
    assign insert = !hit && is_put;
    assign evict  = insert && occ_ge_cap && (occ_reg != '0) && lru_vld_reg;
    // insert slot: lowest invalid slot after the eviction
    assign slot_idx = (evict && (!free_vld_reg || (lru_idx_reg < free_idx_reg)))
                      ? lru_idx_reg : free_idx_reg;

    assign out_free = !out_vld_reg || !rsp_stall;

    // ------------------------------------------------------------------
    // Rank read-modify-write during the update sweep
    // ------------------------------------------------------------------
    always_comb
    begin
        rank_we    = 1'b0;
        rank_wdata = rank_rd_reg + RANK_W'(1);
        if ((state_reg == ST_UPDATE) && p_vld_reg)
        begin
            if (hit)
            begin
                // entries more recent than the touched one step back
                if (v_cur && (p_idx_reg == found_idx_reg))
                begin
                    rank_we    = 1'b1;
                    rank_wdata = '0;
                end
                else if (v_cur && (rank_rd_reg < found_rank_reg))
                begin
                    rank_we = 1'b1;
                end
            end
            else if (insert)
            begin
                // new entry is most recent, every surviving entry ages
                if (p_idx_reg == slot_idx)
                begin
                    rank_we    = 1'b1;
                    rank_wdata = '0;
                end
                else if (v_cur && !(evict && (p_idx_reg == lru_idx_reg)))
                begin
                    rank_we = 1'b1;
                end
            end
        end
    end

    // key and value are written together, once, on the last update cycle;
    // a put hit rewrites the key it matched
    assign kv_we     = (state_reg == ST_UPDATE) && last && is_put;
    assign kv_wr_idx = hit ? found_idx_reg : slot_idx;
    // search sweep walks every slot, update sweep parks on the hit slot
    assign kv_rd_idx = (state_reg == ST_UPDATE) ? found_idx_reg : rd_idx;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (kv_we)
        begin
            kv_mem[kv_wr_idx] <= {item_reg.lookup_key, item_reg.write_value};
        end
        {key_rd_reg, val_rd_reg} <= kv_mem[kv_rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[p_idx_reg] <= rank_wdata;
        end
        rank_rd_reg <= rank_mem[rd_idx];
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == lru_kv_pkg::REG_CAPACITY);

    always_comb
    begin
        if (paddr[2] == lru_kv_pkg::REG_CAPACITY)
        begin
            prdata = lru_kv_pkg::APB_DATA_W'(cap_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = issue ? cnt_reg + CNT_W'(1) : cnt_reg;
        p_vld_next      = issue;
        p_idx_next      = rd_idx;
        found_vld_next  = found_vld_reg;
        lru_vld_next    = lru_vld_reg;
        free_vld_next   = free_vld_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        cap_next        = cfg_wr ? pwdata[lru_kv_pkg::CAP_W-1:0] : cap_reg;
        out_vld_next    = out_vld_reg && rsp_stall;

        item_next       = item_reg;
        found_idx_next  = found_idx_reg;
        found_rank_next = found_rank_reg;
        lru_idx_next    = lru_idx_reg;
        lru_rank_next   = lru_rank_reg;
        lru_key_next    = lru_key_reg;
        free_idx_next   = free_idx_reg;
        res_next        = res_reg;
        out_next        = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next      = req_item;
                    cnt_next       = '0;
                    p_vld_next     = 1'b0;
                    found_vld_next = 1'b0;
                    lru_vld_next   = 1'b0;
                    free_vld_next  = 1'b0;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (p_vld_reg)
                begin
                    // first valid key match
                    if (!found_vld_reg && v_cur && (key_rd_reg == item_reg.lookup_key))
                    begin
                        found_vld_next  = 1'b1;
                        found_idx_next  = p_idx_reg;
                        found_rank_next = rank_rd_reg;
                    end
                    // first valid entry with the largest rank
                    if (v_cur && (!lru_vld_reg || (rank_rd_reg > lru_rank_reg)))
                    begin
                        lru_vld_next  = 1'b1;
                        lru_idx_next  = p_idx_reg;
                        lru_rank_next = rank_rd_reg;
                        lru_key_next  = key_rd_reg;
                    end
                    // lowest free slot
                    if (!v_cur && !free_vld_reg)
                    begin
                        free_vld_next = 1'b1;
                        free_idx_next = p_idx_reg;
                    end
                    if (last)
                    begin
                        cnt_next   = '0;
                        state_next = ST_UPDATE;
                    end
                end
            end

            ST_UPDATE:
            begin
                if (last)
                begin
                    if (evict)
                    begin
                        valid_next[lru_idx_reg] = 1'b0;
                    end
                    if (insert)
                    begin
                        valid_next[slot_idx] = 1'b1;
                    end
                    occ_next = occ_reg - CNT_W'(evict) + CNT_W'(insert);

                    res_next.hit         = hit;
                    res_next.read_value  = (hit && !is_put) ? val_rd_reg : '0;
                    res_next.evicted     = evict;
                    res_next.evicted_key = evict ? lru_key_reg : '0;
                    state_next           = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    out_next     = res_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            p_vld_reg     <= 1'b0;
            p_idx_reg     <= '0;
            found_vld_reg <= 1'b0;
            lru_vld_reg   <= 1'b0;
            free_vld_reg  <= 1'b0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            cap_reg       <= lru_kv_pkg::CAP_RESET;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            p_vld_reg     <= p_vld_next;
            p_idx_reg     <= p_idx_next;
            found_vld_reg <= found_vld_next;
            lru_vld_reg   <= lru_vld_next;
            free_vld_reg  <= free_vld_next;
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            cap_reg       <= cap_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        found_idx_reg  <= found_idx_next;
        found_rank_reg <= found_rank_next;
        lru_idx_reg    <= lru_idx_next;
        lru_rank_reg   <= lru_rank_next;
        lru_key_reg    <= lru_key_next;
        free_idx_reg   <= free_idx_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_vld_reg;
    assign rsp_item  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    // occupancy count tracks the valid bits
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy count out of step with valid bits");

    // an accepted request always starts the search sweep
    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == ST_SCAN))
        else $error("accepted request did not start a search");

    // after any put the store holds at least one entry
    a_put_occupies: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && is_put) |-> (occ_reg != '0))
        else $error("put left the store empty");

    // a response never reports both a hit and an eviction
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !(rsp_item.hit && rsp_item.evicted))
        else $error("hit and eviction in one response");
`endif

endmodule

`default_nettype wire

### tb/lru_cache_checker.sv
`default_nettype none

// Watches both channels and the config port, keeps a shadow copy of the
// cache and compares each response transaction with the oldest prediction.
module lru_cache_checker
    import lru_kv_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     req_valid,
    input  wire                     req_stall,
    input  wire req_item_t          req_item,
    input  wire                     rsp_valid,
    input  wire                     rsp_stall,
    input  wire rsp_item_t          rsp_item,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [APB_ADDR_W-1:0]   paddr,
    input  wire  [APB_DATA_W-1:0]   pwdata,
    input  wire                     pready,
    output int                      mismatches,
    output int                      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = ENTRIES_DEF;

    logic [KEY_BITS-1:0]   slot_key [SLOTS];
    logic [VALUE_BITS-1:0] slot_val [SLOTS];
    bit                    slot_live[SLOTS];
    int unsigned           slot_age [SLOTS];
    int unsigned           live_count;
    logic [CAP_W-1:0]      cap_reg;

    rsp_item_t             expected_q[$];
    rsp_item_t             want;
    int                    fail_count;

    task automatic flag(input string what, input logic [31:0] got, input logic [31:0] exp_val);
        $display("%0t mismatch: %s got %0h, want %0h", $time, what, got, exp_val);
        fail_count++;
    endtask

    // Applies one get/put to the shadow cache and returns its response.
    function automatic rsp_item_t apply_op(input req_item_t op);
        rsp_item_t   r;
        int          found;
        int          lru;
        int          free_slot;
        int unsigned eff_cap;
        int unsigned oldest;
        int unsigned age;

        r         = '0;
        found     = -1;
        lru       = -1;
        free_slot = -1;
        oldest    = 0;
        if (cap_reg == 0)
            eff_cap = 1;
        else if (int'(cap_reg) > SLOTS)
            eff_cap = SLOTS;
        else
            eff_cap = cap_reg;

        for (int i = 0; i < SLOTS; i++)
            if (found < 0 && slot_live[i] && slot_key[i] == op.lookup_key)
                found = i;

        if (found >= 0)
        begin
            r.hit = 1'b1;
            if (op.kind == KIND_PUT)
                slot_val[found] = op.write_value;
            else
                r.read_value = slot_val[found];
            // move to front, entries that were newer age by one
            age = slot_age[found];
            for (int i = 0; i < SLOTS; i++)
                if (slot_live[i] && i != found && slot_age[i] < age)
                    slot_age[i]++;
            slot_age[found] = 0;
        end
        else if (op.kind == KIND_PUT)
        begin
            if (live_count >= eff_cap && live_count > 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i] && (lru < 0 || slot_age[i] > oldest))
                    begin
                        lru    = i;
                        oldest = slot_age[i];
                    end
                if (lru >= 0)
                begin
                    r.evicted     = 1'b1;
                    r.evicted_key = slot_key[lru];
                    slot_live[lru] = 1'b0;
                    live_count--;
                end
            end
            for (int i = 0; i < SLOTS; i++)
                if (free_slot < 0 && !slot_live[i])
                    free_slot = i;
            if (free_slot >= 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i])
                        slot_age[i]++;
                slot_key[free_slot]  = op.lookup_key;
                slot_val[free_slot]  = op.write_value;
                slot_live[free_slot] = 1'b1;
                slot_age[free_slot]  = 0;
                live_count++;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_live[i] = 1'b0;
                slot_age[i]  = 0;
            end
            live_count = 0;
            cap_reg    = CAP_RESET;
            fail_count = 0;
            expected_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // responses first: a response on this edge belongs to an older request
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                    flag("response with nothing pending", 32'(rsp_item.read_value), 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp_item.hit !== want.hit)
                        flag("hit", 32'(rsp_item.hit), 32'(want.hit));
                    if (rsp_item.read_value !== want.read_value)
                        flag("read_value", 32'(rsp_item.read_value), 32'(want.read_value));
                    if (rsp_item.evicted !== want.evicted)
                        flag("evicted", 32'(rsp_item.evicted), 32'(want.evicted));
                    if (rsp_item.evicted_key !== want.evicted_key)
                        flag("evicted_key", 32'(rsp_item.evicted_key),
                             32'(want.evicted_key));
                end
            end

            if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
                cap_reg = pwdata[CAP_W-1:0];

            if (req_valid && !req_stall)
                expected_q.push_back(apply_op(req_item));

            mismatches  <= fail_count;
            outstanding <= expected_q.size();
        end
    end

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

// Top of the LRU cache bench.
//
// Stimulus only: the checker instance beside the DUT predicts and compares
// every response transaction. Inputs change on the falling edge, so they
// are stable at the rising edge where the DUT and the checker sample them.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lru_kv_pkg::*;

    // Item time grows with the two sweeps plus sender gaps and receiver
    // stalls; the limit is ample for the ~825 items sent.
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 2 * ENTRIES_DEF + 12;
    localparam int PHASES      = 8;
    localparam int PHASE_OPS   = 100;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   req_valid;
    logic                   req_stall;
    req_item_t              req_item;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_item_t              rsp_item;

    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int                     mismatches;
    int                     outstanding;
    int                     cycle_count = 0;

    // idle percentages, changed per phase by the stimulus
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;

    always #5 clk = ~clk;

    lru_key_value_cache DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    lru_cache_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_item    (req_item),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_item    (rsp_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Receiver back-pressure: one fresh decision per falling edge.
    always @(negedge clk)
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // Watchdog: covers a hung DUT and predictions that never get a response.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Called at a falling edge, returns at the falling edge after the
    // transaction is taken. valid stays high into the next call, which
    // either keeps it up or drops it for a gap: one assignment per edge.
    task automatic send_op(input logic kind, input logic [KEY_BITS-1:0] key,
                           input logic [VALUE_BITS-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= '{kind: kind, lookup_key: key, write_value: val};
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted response has been seen.
    task automatic drain();
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_capacity(input int unsigned cap);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= APB_DATA_W'(cap);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        int unsigned         cap_plan[PHASES];
        int unsigned         eff_cap;
        int                  pool_size;
        logic [KEY_BITS-1:0] key_pool[32];
        logic [KEY_BITS-1:0] key;
        logic                kind;

        req_valid = 1'b0;
        req_item  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 35;
        recv_idle_pct = 81;

        // ---- directed, capacity at its reset value of 16 ----
        send_op(KIND_GET, 16'h0000, 16'h0000);    // miss on an empty cache
        send_op(KIND_PUT, 16'h0000, 16'hFFFF);
        send_op(KIND_PUT, 16'hFFFF, 16'h0000);
        send_op(KIND_GET, 16'hFFFF, 16'hFFFF);    // hit, value ignored on get
        send_op(KIND_GET, 16'h0000, 16'h0000);
        send_op(KIND_PUT, 16'h0000, 16'hA5A5);    // update of a present key
        send_op(KIND_GET, 16'h1234, 16'h0000);    // miss on a partly full cache
        drain();

        // zero capacity acts as one, and is now below the two entries held:
        // each put miss evicts just the oldest entry
        write_capacity(0);
        send_op(KIND_PUT, 16'h1111, 16'h5A5A);
        send_op(KIND_PUT, 16'h2222, 16'h0001);
        send_op(KIND_GET, 16'h1111, 16'h0000);
        send_op(KIND_GET, 16'hFFFF, 16'h0000);    // evicted above
        drain();

        // capacity above the built size is clamped to ENTRIES
        write_capacity(31);
        for (int j = 0; j < 6; j++)
            send_op(KIND_PUT, 16'h0001 << (2 * j), ~(16'h0001 << (2 * j)));
        send_op(KIND_GET, 16'h0004, 16'h0000);
        drain();

        // capacity one, below the entries held: each put miss evicts the oldest entry
        write_capacity(1);
        send_op(KIND_PUT, 16'hAAAA, 16'h5555);
        send_op(KIND_PUT, 16'h5555, 16'hAAAA);
        send_op(KIND_GET, 16'h5555, 16'h0000);
        send_op(KIND_GET, 16'hAAAA, 16'h0000);
        send_op(KIND_PUT, 16'h5555, 16'hFFFF);
        drain();

        // ---- random phases ----
        // Keys come mostly from a per-phase pool a little larger than the
        // usable capacity, so gets hit, puts update and misses evict.
        cap_plan = '{16, 1, 31, 0, $urandom_range(2, 15), 8, $urandom_range(0, 31), 16};
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 35;
                recv_idle_pct = 81;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 35;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            write_capacity(cap_plan[phase]);
            if (cap_plan[phase] == 0)
                eff_cap = 1;
            else if (cap_plan[phase] > ENTRIES_DEF)
                eff_cap = ENTRIES_DEF;
            else
                eff_cap = cap_plan[phase];
            pool_size = eff_cap + $urandom_range(1, 8);
            for (int j = 0; j < pool_size; j++)
                key_pool[j] = KEY_BITS'($urandom);

            for (int n = 0; n < PHASE_OPS; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    key = KEY_BITS'($urandom);
                else
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                kind = ($urandom_range(0, 1) == 1) ? KIND_PUT : KIND_GET;
                send_op(kind, key, VALUE_BITS'($urandom));
            end
            drain();
        end

        // a few extra cycles in case the DUT emits something unasked
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/lru_kv_pkg.sv
rtl/lru_key_value_cache.sv
tb/lru_cache_checker.sv
tb/tb.sv
